FILE: rtl/lswf_pkg.sv
// ----------------------------------------------------------------------------
// Lamp sleep/wake fade timer package
// Field widths, command codes, controller states and timing constants.
// ----------------------------------------------------------------------------
package lswf_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned DUR_W   = 11;
  localparam int unsigned LEVEL_W = 8;

  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned FULL_LEVEL    = 255;
  localparam int unsigned FADE_MS_DEF   = 60000;

  // 60000 ms times an 11-bit minute count fits in 27 bits
  localparam int unsigned SPAN_W = 27;
  // divider dividend: level times a 32-bit time
  localparam int unsigned DVD_W  = TIME_W + LEVEL_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_SLEEP_START = 3'd1,
    CMD_SLEEP_STOP  = 3'd2,
    CMD_WAKE_START  = 3'd3,
    CMD_WAKE_STOP   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/lswf_if.sv
// ----------------------------------------------------------------------------
// Lamp sleep/wake fade timer channels
// Command channel and result channel, valid/ready with flat payload.
// ----------------------------------------------------------------------------
interface lswf_in_if;
  import lswf_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TIME_W-1:0]  now_ms;
  logic [HOUR_W-1:0]  clock_hour;
  logic [MIN_W-1:0]   clock_minute;
  logic [DUR_W-1:0]   minutes;
  logic [HOUR_W-1:0]  target_hour;
  logic [MIN_W-1:0]   target_minute;
  logic [LEVEL_W-1:0] current_level;

  modport source (
    output valid, command, now_ms, clock_hour, clock_minute, minutes,
           target_hour, target_minute, current_level,
    input  ready
  );

  modport sink (
    input  valid, command, now_ms, clock_hour, clock_minute, minutes,
           target_hour, target_minute, current_level,
    output ready
  );
endinterface

interface lswf_out_if;
  import lswf_pkg::*;

  logic               valid;
  logic               ready;
  logic               level_write;
  logic [LEVEL_W-1:0] level;
  logic               sleep_running;
  logic               wake_enabled;
  logic               wake_ramping;
  logic [TIME_W-1:0]  sleep_left_ms;

  modport source (
    output valid, level_write, level, sleep_running, wake_enabled,
           wake_ramping, sleep_left_ms,
    input  ready
  );

  modport sink (
    input  valid, level_write, level, sleep_running, wake_enabled,
           wake_ramping, sleep_left_ms,
    output ready
  );
endinterface

FILE: rtl/lamp_sleep_wake_fade_timer_top.sv
// ----------------------------------------------------------------------------
// Lamp sleep/wake fade timer
// One command per transfer on in_i (tick, start/stop sleep, start/stop wake);
// one result per command on out_o with the level to write and timer status.
//
// Usage:
//   - in_i carries a command plus the current time, wall clock, duration,
//     wake target and lamp level. A transfer happens when valid and ready
//     are both high; ready is high only while the controller is idle.
//   - out_o returns exactly one result per command, in order.
//   - Commands without a fade or ramp quotient pass through the evaluate,
//     decide and done states before the next possible transfer; the result
//     is loaded into the output register in the done state.
//   - A tick that fades the sleep level or ramps the wake level also runs
//     the multiply and divide states: the level comes out of a bit-serial
//     restoring divider, one quotient bit per cycle, 40-bit dividend.
//   - The result sits in an output register. A new command is accepted
//     while it waits; if out_o is still stalled when the next result is
//     ready, the controller holds in its final state until the transfer.
//   - Reset clears both timers (sleep off, wake off and unarmed, all times
//     zero) and empties the output register.
// ----------------------------------------------------------------------------
module lamp_sleep_wake_fade_timer_top #(
  parameter int unsigned FADE_MS = lswf_pkg::FADE_MS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lswf_in_if.sink    in_i,
  lswf_out_if.source out_o
);
  import lswf_pkg::*;

  localparam logic [TIME_W-1:0]  FadeMs    = TIME_W'(FADE_MS);
  localparam logic [LEVEL_W-1:0] FullLevel = LEVEL_W'(FULL_LEVEL);
  localparam logic [SPAN_W-1:0]  MinuteMs  = SPAN_W'(MS_PER_MINUTE);

  // --------------------------------------------------------------------------
  // Controller state and handshake strobes
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic in_ready;
  logic load_in;
  logic do_eval;
  logic do_decide;
  logic do_mul;
  logic do_div;
  logic load_out;
  logic need_div;

  // --------------------------------------------------------------------------
  // Captured command
  // --------------------------------------------------------------------------
  logic [CMD_W-1:0]   cmd_q;
  logic [TIME_W-1:0]  now_q;
  logic [HOUR_W-1:0]  hour_q;
  logic [MIN_W-1:0]   minute_q;
  logic [DUR_W-1:0]   mins_q;
  logic [HOUR_W-1:0]  thour_q;
  logic [MIN_W-1:0]   tmin_q;
  logic [LEVEL_W-1:0] cur_q;

  // --------------------------------------------------------------------------
  // Timer state
  // --------------------------------------------------------------------------
  logic               sleep_on_q,    sleep_on_d;
  logic [TIME_W-1:0]  sleep_end_q,   sleep_end_d;
  logic [LEVEL_W-1:0] sleep_saved_q, sleep_saved_d;
  logic               wake_on_q,     wake_on_d;
  logic               wake_armed_q,  wake_armed_d;
  logic [TIME_W-1:0]  wake_begin_q,  wake_begin_d;
  logic [TIME_W-1:0]  wake_end_q,    wake_end_d;
  logic [HOUR_W-1:0]  wake_hour_q,   wake_hour_d;
  logic [MIN_W-1:0]   wake_minute_q, wake_minute_d;
  logic [DUR_W-1:0]   wake_dur_q,    wake_dur_d;

  // --------------------------------------------------------------------------
  // Evaluation registers (one subtract, compare or multiply each)
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] sleep_left_q;
  logic              sleep_ge_q;
  logic [TIME_W-1:0] fade_start_q;
  logic [TIME_W-1:0] wake_left_q;
  logic [TIME_W-1:0] wake_total_q;
  logic              wake_le_q;
  logic [SPAN_W-1:0] span_q;
  logic [DUR_W-1:0]  span_mins;
  logic [TIME_W-1:0] span_end;

  // decision results
  logic               s_write, s_div;
  logic               w_write, w_div;
  logic [LEVEL_W-1:0] w_level;
  logic               c_write;
  logic [LEVEL_W-1:0] c_level;

  logic [TIME_W-1:0]  elapsed_q;
  logic               res_write_q;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_div_q;
  logic               div_wake_q;
  logic [TIME_W-1:0]  res_left_q;

  // --------------------------------------------------------------------------
  // Bit-serial divider
  // --------------------------------------------------------------------------
  logic [DVD_W-1:0]   dvd_q;
  logic [TIME_W-1:0]  dvs_q;
  logic [TIME_W-1:0]  rem_q;
  logic [LEVEL_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LEVEL_W-1:0] mul_a;
  logic [TIME_W-1:0]  mul_b;
  logic [TIME_W:0]    div_trial;
  logic [TIME_W:0]    div_diff;
  logic               div_ge;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_valid_q, out_valid_d;
  logic               out_write_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic               out_sleep_q;
  logic               out_wake_q;
  logic               out_ramp_q;
  logic [TIME_W-1:0]  out_left_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = need_div ? ST_MUL : ST_DONE;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (cnt_q == CNT_W'(1)) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    do_eval   = 1'b0;
    do_decide = 1'b0;
    do_mul    = 1'b0;
    do_div    = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready  = 1'b1;
      ST_EVAL:   do_eval   = 1'b1;
      ST_DECIDE: do_decide = 1'b1;
      ST_MUL:    do_mul    = 1'b1;
      ST_DIV:    do_div    = 1'b1;
      ST_DONE:   load_out  = !out_valid_q || out_o.ready;
      default:   in_ready  = 1'b0;
    endcase
  end

  assign load_in = in_ready && in_i.valid;

  // --------------------------------------------------------------------------
  // Shared datapath pieces
  // --------------------------------------------------------------------------
  // start sleep uses the command's minutes, arming the wake uses the stored one
  assign span_mins = (cmd_q == CMD_SLEEP_START) ? mins_q : wake_dur_q;
  assign span_end  = now_q + TIME_W'(span_q);

  // one multiplier feeds the divider: level * time
  assign mul_a = div_wake_q ? FullLevel : sleep_saved_q;
  assign mul_b = div_wake_q ? elapsed_q : sleep_left_q;

  assign div_trial = {rem_q, dvd_q[DVD_W-1]};
  assign div_diff  = div_trial - {1'b0, dvs_q};
  assign div_ge    = div_trial >= {1'b0, dvs_q};

  // --------------------------------------------------------------------------
  // Command decision; timer state commits in the decide cycle
  // --------------------------------------------------------------------------
  always_comb begin
    sleep_on_d    = sleep_on_q;
    sleep_end_d   = sleep_end_q;
    sleep_saved_d = sleep_saved_q;
    wake_on_d     = wake_on_q;
    wake_armed_d  = wake_armed_q;
    wake_begin_d  = wake_begin_q;
    wake_end_d    = wake_end_q;
    wake_hour_d   = wake_hour_q;
    wake_minute_d = wake_minute_q;
    wake_dur_d    = wake_dur_q;
    s_write       = 1'b0;
    s_div         = 1'b0;
    w_write       = 1'b0;
    w_div         = 1'b0;
    w_level       = '0;
    c_write       = 1'b0;
    c_level       = '0;
    if (state_q == ST_DECIDE) begin
      unique case (cmd_q)
        CMD_TICK: begin
          if (sleep_on_q) begin
            if (sleep_ge_q) begin
              // end reached: lamp off, timer off
              s_write    = 1'b1;
              sleep_on_d = 1'b0;
            end else if (now_q > fade_start_q) begin
              s_write = 1'b1;
              s_div   = 1'b1;
            end
          end
          if (wake_on_q) begin
            if (!wake_armed_q) begin
              if (hour_q == wake_hour_q && minute_q == wake_minute_q) begin
                wake_armed_d = 1'b1;
                wake_begin_d = now_q;
                wake_end_d   = span_end;
              end
            end else if (wake_le_q) begin
              w_write = 1'b1;
              if (wake_total_q == '0) begin
                w_level = FullLevel;
              end else if (wake_left_q > wake_total_q) begin
                // time wrapped behind the ramp start
                w_level = '0;
              end else begin
                w_div = 1'b1;
              end
            end else begin
              wake_armed_d = 1'b0;
              wake_on_d    = 1'b0;
            end
          end
        end
        CMD_SLEEP_START: begin
          sleep_on_d    = 1'b1;
          sleep_end_d   = span_end;
          sleep_saved_d = cur_q;
        end
        CMD_SLEEP_STOP: begin
          if (sleep_on_q) begin
            sleep_on_d = 1'b0;
            c_write    = 1'b1;
            c_level    = sleep_saved_q;
          end
        end
        CMD_WAKE_START: begin
          wake_hour_d   = thour_q;
          wake_minute_d = tmin_q;
          wake_dur_d    = mins_q;
          wake_on_d     = 1'b1;
        end
        CMD_WAKE_STOP: begin
          wake_armed_d = 1'b0;
          wake_on_d    = 1'b0;
        end
        default: begin
          c_write = 1'b0;
        end
      endcase
    end
  end

  // wake level wins when both timers write on one tick
  assign need_div = w_write ? w_div : s_div;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Control and timer registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      sleep_on_q    <= 1'b0;
      sleep_end_q   <= '0;
      sleep_saved_q <= '0;
      wake_on_q     <= 1'b0;
      wake_armed_q  <= 1'b0;
      wake_begin_q  <= '0;
      wake_end_q    <= '0;
      wake_hour_q   <= '0;
      wake_minute_q <= '0;
      wake_dur_q    <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      sleep_on_q    <= sleep_on_d;
      sleep_end_q   <= sleep_end_d;
      sleep_saved_q <= sleep_saved_d;
      wake_on_q     <= wake_on_d;
      wake_armed_q  <= wake_armed_d;
      wake_begin_q  <= wake_begin_d;
      wake_end_q    <= wake_end_d;
      wake_hour_q   <= wake_hour_d;
      wake_minute_q <= wake_minute_d;
      wake_dur_q    <= wake_dur_d;
      if (do_mul) begin
        cnt_q <= CNT_W'(DVD_W);
      end else if (do_div) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      cmd_q    <= in_i.command;
      now_q    <= in_i.now_ms;
      hour_q   <= in_i.clock_hour;
      minute_q <= in_i.clock_minute;
      mins_q   <= in_i.minutes;
      thour_q  <= in_i.target_hour;
      tmin_q   <= in_i.target_minute;
      cur_q    <= in_i.current_level;
    end

    if (do_eval) begin
      sleep_left_q <= sleep_end_q - now_q;
      sleep_ge_q   <= now_q >= sleep_end_q;
      fade_start_q <= sleep_end_q - FadeMs;
      wake_left_q  <= wake_end_q - now_q;
      wake_total_q <= wake_end_q - wake_begin_q;
      wake_le_q    <= now_q <= wake_end_q;
      span_q       <= {{(SPAN_W-DUR_W){1'b0}}, span_mins} * MinuteMs;
    end

    if (do_decide) begin
      elapsed_q   <= wake_total_q - wake_left_q;
      res_write_q <= s_write || w_write || c_write;
      res_level_q <= w_write ? w_level : c_level;
      res_div_q   <= need_div;
      div_wake_q  <= w_write;
      // after start sleep, end minus now is the span itself
      res_left_q  <= (cmd_q == CMD_SLEEP_START) ? TIME_W'(span_q) : sleep_left_q;
    end

    if (do_mul) begin
      dvd_q <= DVD_W'(mul_a) * DVD_W'(mul_b);
      dvs_q <= div_wake_q ? wake_total_q : FadeMs;
      rem_q <= '0;
    end else if (do_div) begin
      rem_q <= div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[LEVEL_W-2:0], div_ge};
    end

    if (load_out) begin
      out_write_q <= res_write_q;
      out_level_q <= res_div_q ? quo_q : res_level_q;
      out_sleep_q <= sleep_on_q;
      out_wake_q  <= wake_on_q;
      out_ramp_q  <= wake_armed_q;
      out_left_q  <= res_left_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.level_write   = out_write_q;
  assign out_o.level         = out_level_q;
  assign out_o.sleep_running = out_sleep_q;
  assign out_o.wake_enabled  = out_wake_q;
  assign out_o.wake_ramping  = out_ramp_q;
  assign out_o.sleep_left_ms = out_left_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_armed_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wake_armed_q |-> wake_on_q)
    else $error("wake ramp armed while wake timer disabled");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q > CNT_W'(LEVEL_W)) |-> !div_ge)
    else $error("quotient exceeds level width");

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_write_q) |-> (out_level_q == '0))
    else $error("nonzero level without a level write");

endmodule
